// ===== rtl/pus_pkg.sv =====
package pus_pkg;

  localparam int WORD_W  = 32;
  localparam int OFF_W   = 5;
  localparam int INDEX_W = 12;
  localparam int WIDTH_W = 6;
  localparam int COUNT_W = 13;
  localparam int VALUE_W = 32;
  localparam int POS_W   = INDEX_W + WIDTH_W;
  localparam int TDATA_W = 48;

  localparam logic [WIDTH_W-1:0] UNIT_WIDTH_RESET = 6'd8;
  localparam logic [COUNT_W-1:0] UNIT_COUNT_RESET = 13'd4096;

  typedef enum logic {
    CFG_UNIT_WIDTH = 1'b0,
    CFG_UNIT_COUNT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_READ  = 1'b1
  } kind_t;

endpackage

// ===== rtl/packed_unit_store.sv =====
// Packed unit store: units of unit_width bits lie back to back, least significant bit
// first, in a single-port 32-bit word memory with a registered read. Each item takes
// one memory read per word that the unit touches, then on a write one write per word;
// an index error touches no memory. One item is in flight at a time. After reset a
// clearing pass writes zeros to all MAX_UNITS*MAX_WIDTH/32 words before the first
// item is taken; configuration writes are taken throughout.
module packed_unit_store #(
  parameter int MAX_UNITS = 4096,
  parameter int MAX_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [pus_pkg::COUNT_W-1:0]   cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // unit_index, write_value
  input  logic [pus_pkg::TDATA_W-1:0]   s_tdata,
  // kind
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // read_value
  output logic [pus_pkg::VALUE_W-1:0]   m_tdata,
  // index_error
  output logic                          m_tuser
);

  localparam int DEPTH = (MAX_UNITS * MAX_WIDTH + pus_pkg::WORD_W - 1) / pus_pkg::WORD_W;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD0, S_RD1, S_CAP, S_WR0, S_WR1, S_DONE
  } state_t;

  state_t                          state;
  logic [pus_pkg::WIDTH_W-1:0]     unit_width;
  logic [pus_pkg::COUNT_W-1:0]     unit_count;
  logic [AW-1:0]                   clr_addr;

  logic                            kind;
  logic                            err;
  logic                            straddle;
  logic [pus_pkg::POS_W-1:0]       pos;
  logic [pus_pkg::VALUE_W-1:0]     mask;
  logic [pus_pkg::VALUE_W-1:0]     value;
  logic [pus_pkg::WORD_W-1:0]      lo_word;
  logic [pus_pkg::VALUE_W-1:0]     result;
  logic [2*pus_pkg::WORD_W-1:0]    merged_q;

  logic [pus_pkg::WIDTH_W-1:0]     w_eff;
  logic [pus_pkg::INDEX_W-1:0]     in_index;
  logic [pus_pkg::POS_W-1:0]       pos_in;
  logic                            err_in;
  logic [AW-1:0]                   wa0;
  logic [AW-1:0]                   wa1;

  logic                            mem_rd;
  logic                            mem_wr;
  logic [AW-1:0]                   mem_addr;
  logic [pus_pkg::WORD_W-1:0]      mem_wdata;
  logic [pus_pkg::WORD_W-1:0]      mem_rdata;

  logic [2*pus_pkg::WORD_W-1:0]    window;
  logic [pus_pkg::VALUE_W-1:0]     unit_value;
  logic [2*pus_pkg::WORD_W-1:0]    merged;

  assign s_tready = (state == S_IDLE);
  assign in_index = s_tdata[pus_pkg::INDEX_W-1:0];

  always_comb begin
    w_eff  = (32'(unit_width) > MAX_WIDTH) ? pus_pkg::WIDTH_W'(MAX_WIDTH) : unit_width;
    pos_in = pus_pkg::POS_W'(in_index) * pus_pkg::POS_W'(w_eff);
    err_in = (in_index >= pus_pkg::INDEX_W'(0) + unit_count[pus_pkg::INDEX_W-1:0]
              && unit_count[pus_pkg::COUNT_W-1] == 1'b0)
             || (32'(in_index) >= MAX_UNITS);
    wa0    = AW'(pos >> pus_pkg::OFF_W);
    wa1    = wa0 + AW'(1);
    window = {((state == S_CAP) && straddle) ? mem_rdata : {pus_pkg::WORD_W{1'b0}},
              lo_word};
  end

  always_comb begin
    mem_rd    = 1'b0;
    mem_wr    = 1'b0;
    mem_addr  = wa0;
    mem_wdata = merged_q[pus_pkg::WORD_W-1:0];
    unique case (state)
      S_CLEAR: begin
        mem_wr    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
      end
      S_RD0: begin
        mem_rd = 1'b1;
      end
      S_RD1: begin
        mem_rd   = straddle;
        mem_addr = wa1;
      end
      S_WR0: begin
        mem_wr = 1'b1;
      end
      S_WR1: begin
        mem_wr    = 1'b1;
        mem_addr  = wa1;
        mem_wdata = merged_q[2*pus_pkg::WORD_W-1:pus_pkg::WORD_W];
      end
      S_IDLE, S_CAP, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  pus_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .rd_en (mem_rd),
    .wr_en (mem_wr),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  pus_field u_field (
    .window     (window),
    .off        (pos[pus_pkg::OFF_W-1:0]),
    .mask       (mask),
    .value      (value),
    .unit_value (unit_value),
    .merged     (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_width <= pus_pkg::UNIT_WIDTH_RESET;
      unit_count <= pus_pkg::UNIT_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pus_pkg::CFG_UNIT_WIDTH: unit_width <= cfg_data[pus_pkg::WIDTH_W-1:0];
        pus_pkg::CFG_UNIT_COUNT: unit_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            kind     <= s_tuser;
            err      <= err_in;
            pos      <= pos_in;
            value    <= s_tdata[pus_pkg::INDEX_W +: pus_pkg::VALUE_W];
            mask     <= pus_pkg::VALUE_W'((33'h1 << w_eff) - 33'h1);
            straddle <= (7'(pos_in[pus_pkg::OFF_W-1:0]) + 7'(w_eff)) > 7'(pus_pkg::WORD_W);
            result   <= '0;
            state    <= err_in ? S_DONE : S_RD0;
          end
        end
        S_RD0: begin
          state <= S_RD1;
        end
        S_RD1: begin
          lo_word <= mem_rdata;
          state   <= S_CAP;
        end
        S_CAP: begin
          merged_q <= merged;
          if (kind == pus_pkg::KIND_READ) begin
            result <= unit_value;
            state  <= S_DONE;
          end else begin
            state <= S_WR0;
          end
        end
        S_WR0: begin
          state <= straddle ? S_WR1 : S_DONE;
        end
        S_WR1: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= result;
            m_tuser  <= err;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/pus_mem.sv =====
module pus_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic                       wr_en,
  input  logic [AW-1:0]              addr,
  input  logic [pus_pkg::WORD_W-1:0] wdata,
  output logic [pus_pkg::WORD_W-1:0] rdata
);

  logic [pus_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/pus_field.sv =====
module pus_field (
  input  logic [2*pus_pkg::WORD_W-1:0]  window,
  input  logic [pus_pkg::OFF_W-1:0]     off,
  input  logic [pus_pkg::VALUE_W-1:0]   mask,
  input  logic [pus_pkg::VALUE_W-1:0]   value,
  output logic [pus_pkg::VALUE_W-1:0]   unit_value,
  output logic [2*pus_pkg::WORD_W-1:0]  merged
);

  logic [2*pus_pkg::WORD_W-1:0] mask_wide;
  logic [2*pus_pkg::WORD_W-1:0] value_wide;

  always_comb begin
    mask_wide  = {{pus_pkg::WORD_W{1'b0}}, mask} << off;
    value_wide = {{pus_pkg::WORD_W{1'b0}}, value & mask} << off;
    unit_value = pus_pkg::VALUE_W'(window >> off) & mask;
    merged     = (window & ~mask_wide) | value_wide;
  end

endmodule

// ===== rtl/pus_check.sv =====
module pus_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [pus_pkg::TDATA_W-1:0] s_tdata,
  input logic                        s_tuser,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [pus_pkg::VALUE_W-1:0] m_tdata,
  input logic                        m_tuser
);

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("index error item carries a non-zero value");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second item taken while one is in flight");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("item taken during the clearing pass");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled output item changed");

endmodule

bind packed_unit_store pus_check u_check (.*);
